[src/iisq_pkg.sv]
// shared constants, codes and types for the integral and square integral image block
`default_nettype none

package iisq_pkg;

  localparam int PIXEL_W   = 8;
  localparam int SUM_W     = 28;
  localparam int SQ_W      = 36;
  localparam int REG_W     = 11;
  localparam int CFG_IDX_W = 2;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;
  localparam int RESET_DIM      = 24;
  localparam int QUEUE_DEPTH    = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1
  } cfg_reg_e;

  // one classified pixel on its way from the front to the back
  typedef struct packed {
    logic             use_up;
    logic             frame_end;
    logic [SUM_W-1:0] row_sum;
    logic [SQ_W-1:0]  row_sq;
  } item_t;

endpackage

`default_nettype wire

[src/integral_and_square_integral_image.sv]
// top level: streaming summed-area and squared summed-area tables
//
//   beat       direction  handshake                 payload
//   pixel      in         in_valid_i / in_stall_o   pixel_i
//   result     out        out_valid_o / out_stall_i integral_sum_o, square_sum_o, frame_end_o
//   register   in         cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// one pixel per cycle sustained while out_stall_i stays low; each result goes from its pixel
// beat through the queue, the line store read and the output register
// reset: width and height 24, position at origin, line store contents left as they are
// a stall on the output fills the output register, the read stage and the 2-deep queue, then
// in_stall_o rises; cfg_ready_o is always high; a width or height write restarts the frame
`default_nettype none

module integral_and_square_integral_image #(
  parameter int MAX_WIDTH  = iisq_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = iisq_pkg::MAX_HEIGHT_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [iisq_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [iisq_pkg::REG_W-1:0]     cfg_data_i,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic [iisq_pkg::PIXEL_W-1:0]   pixel_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic [iisq_pkg::SUM_W-1:0]          integral_sum_o,
  output logic [iisq_pkg::SQ_W-1:0]           square_sum_o,
  output logic                                frame_end_o
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int EW = $bits(iisq_pkg::item_t) + CW;

  logic            push, q_full, q_valid, q_pop;
  iisq_pkg::item_t push_item, q_item;
  logic [CW-1:0]   push_col, q_col;
  logic [EW-1:0]   q_data;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = q_full;

  iisq_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .pixel_i     (pixel_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .push_item_o (push_item),
    .push_col_o  (push_col)
  );

  iisq_queue #(
    .Width (EW),
    .Depth (iisq_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i ({push_item, push_col}),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .data_o      (q_data)
  );

  assign q_item = q_data[EW-1:CW];
  assign q_col  = q_data[CW-1:0];

  iisq_back #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .q_item_i       (q_item),
    .q_col_i        (q_col),
    .q_pop_o        (q_pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .integral_sum_o (integral_sum_o),
    .square_sum_o   (square_sum_o),
    .frame_end_o    (frame_end_o)
  );

endmodule

`default_nettype wire

[src/iisq_ram.sv]
// generic single write port ram with registered read
`default_nettype none

module iisq_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[src/iisq_front.sv]
// front: configuration registers, raster position and running row sums
`default_nettype none

module iisq_front #(
  parameter int MAX_WIDTH  = iisq_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = iisq_pkg::MAX_HEIGHT_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_valid_i,
  input  wire logic [iisq_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire logic [iisq_pkg::REG_W-1:0]          cfg_data_i,
  input  wire logic                                in_valid_i,
  input  wire logic [iisq_pkg::PIXEL_W-1:0]        pixel_i,
  input  wire logic                                q_full_i,
  output logic                                     push_o,
  output iisq_pkg::item_t                          push_item_o,
  output logic [$clog2(MAX_WIDTH)-1:0]             push_col_o
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int WMW = $clog2(MAX_WIDTH + 1);
  localparam int HMW = $clog2(MAX_HEIGHT + 1);
  localparam int WW  = (iisq_pkg::REG_W > WMW) ? iisq_pkg::REG_W : WMW;
  localparam int HW  = (iisq_pkg::REG_W > HMW) ? iisq_pkg::REG_W : HMW;

  logic [iisq_pkg::REG_W-1:0] width_q, height_q;
  logic [CW-1:0]              col_q, col_d;
  logic [RW-1:0]              row_q, row_d;
  logic [iisq_pkg::SUM_W-1:0] rsum_q, rsum_d;
  logic [iisq_pkg::SQ_W-1:0]  rsq_q, rsq_d;

  logic [WW-1:0] w_raw, w_eff;
  logic [HW-1:0] h_raw, h_eff;
  logic          last_col, last_row, accept, restart;
  logic [2*iisq_pkg::PIXEL_W-1:0] pix_sq;

  assign accept = in_valid_i & ~q_full_i;

  // zero reads as one, anything above the maximum reads as the maximum
  assign w_raw = WW'(width_q);
  assign h_raw = HW'(height_q);
  always_comb begin
    if (w_raw == '0) begin
      w_eff = WW'(1);
    end else if (w_raw > WW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = w_raw;
    end
    if (h_raw == '0) begin
      h_eff = HW'(1);
    end else if (h_raw > HW'(MAX_HEIGHT)) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = h_raw;
    end
  end

  assign last_col = (WW'(col_q) + WW'(1)) >= w_eff;
  assign last_row = (HW'(row_q) + HW'(1)) >= h_eff;

  assign pix_sq = pixel_i * pixel_i;
  assign rsum_d = rsum_q + iisq_pkg::SUM_W'(pixel_i);
  assign rsq_d  = rsq_q + iisq_pkg::SQ_W'(pix_sq);

  always_comb begin
    if (last_col) begin
      col_d = '0;
      row_d = last_row ? '0 : row_q + RW'(1);
    end else begin
      col_d = col_q + CW'(1);
      row_d = row_q;
    end
  end

  assign push_o                = accept;
  assign push_col_o            = col_q;
  assign push_item_o.use_up    = (row_q != '0);
  assign push_item_o.frame_end = last_col & last_row;
  assign push_item_o.row_sum   = rsum_d;
  assign push_item_o.row_sq    = rsq_d;

  always_comb begin
    restart = 1'b0;
    if (cfg_valid_i) begin
      unique case (iisq_pkg::cfg_reg_e'(cfg_index_i))
        iisq_pkg::REG_IMAGE_WIDTH:  restart = 1'b1;
        iisq_pkg::REG_IMAGE_HEIGHT: restart = 1'b1;
        default:                    restart = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= iisq_pkg::REG_W'(iisq_pkg::RESET_DIM);
      height_q <= iisq_pkg::REG_W'(iisq_pkg::RESET_DIM);
      col_q    <= '0;
      row_q    <= '0;
      rsum_q   <= '0;
      rsq_q    <= '0;
    end else if (restart) begin
      if (iisq_pkg::cfg_reg_e'(cfg_index_i) == iisq_pkg::REG_IMAGE_WIDTH) begin
        width_q <= cfg_data_i;
      end else begin
        height_q <= cfg_data_i;
      end
      col_q  <= '0;
      row_q  <= '0;
      rsum_q <= '0;
      rsq_q  <= '0;
    end else if (accept) begin
      col_q  <= col_d;
      row_q  <= row_d;
      rsum_q <= last_col ? '0 : rsum_d;
      rsq_q  <= last_col ? '0 : rsq_d;
    end
  end

endmodule

`default_nettype wire

[src/iisq_queue.sv]
// small fifo between front and back
`default_nettype none

module iisq_queue #(
  parameter int Width = 8,
  parameter int Depth = iisq_pkg::QUEUE_DEPTH
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [Width-1:0] push_data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic                  valid_o,
  output logic      [Width-1:0] data_o
);

  localparam int PW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int NW = $clog2(Depth + 1);

  logic [Width-1:0] buf_q [Depth];
  logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [NW-1:0]    count_q;

  assign full_o  = (count_q == NW'(Depth));
  assign valid_o = (count_q != '0);
  assign data_o  = buf_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PW'(Depth - 1)) ? '0 : wr_ptr_q + PW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PW'(Depth - 1)) ? '0 : rd_ptr_q + PW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + NW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - NW'(1);
      end
    end
  end

endmodule

`default_nettype wire

[src/iisq_back.sv]
// back: line store read, add of the value from above, write back and output register
`default_nettype none

module iisq_back #(
  parameter int MAX_WIDTH = iisq_pkg::MAX_WIDTH_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             q_valid_i,
  input  wire iisq_pkg::item_t                  q_item_i,
  input  wire logic [$clog2(MAX_WIDTH)-1:0]     q_col_i,
  output logic                                  q_pop_o,
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output logic [iisq_pkg::SUM_W-1:0]            integral_sum_o,
  output logic [iisq_pkg::SQ_W-1:0]             square_sum_o,
  output logic                                  frame_end_o
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int LW = iisq_pkg::SUM_W + iisq_pkg::SQ_W;

  logic                       rd_valid_q, out_valid_q;
  iisq_pkg::item_t            rd_item_q;
  logic [CW-1:0]              rd_col_q;
  logic                       rd_fwd_q;
  logic [iisq_pkg::SUM_W-1:0] fwd_sum_q, up_sum, sum_d, out_sum_q;
  logic [iisq_pkg::SQ_W-1:0]  fwd_sq_q, up_sq, sq_d, out_sq_q;
  logic                       out_end_q;
  logic [LW-1:0]              line_rdata;
  logic                       out_free, advance, pop;

  assign out_free = ~out_valid_q | ~out_stall_i;
  assign advance  = rd_valid_q & out_free;
  assign pop      = q_valid_i & (~rd_valid_q | advance);
  assign q_pop_o  = pop;

  // the first row sees zero from above; a same-column write in the read cycle is forwarded
  always_comb begin
    if (!rd_item_q.use_up) begin
      up_sum = '0;
      up_sq  = '0;
    end else if (rd_fwd_q) begin
      up_sum = fwd_sum_q;
      up_sq  = fwd_sq_q;
    end else begin
      up_sum = line_rdata[LW-1:iisq_pkg::SQ_W];
      up_sq  = line_rdata[iisq_pkg::SQ_W-1:0];
    end
  end

  assign sum_d = up_sum + rd_item_q.row_sum;
  assign sq_d  = up_sq + rd_item_q.row_sq;

  iisq_ram #(
    .Width (LW),
    .Depth (MAX_WIDTH)
  ) u_line (
    .clk_i   (clk_i),
    .we_i    (advance),
    .waddr_i (rd_col_q),
    .wdata_i ({sum_d, sq_d}),
    .re_i    (pop),
    .raddr_i (q_col_i),
    .rdata_o (line_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (pop) begin
      rd_item_q <= q_item_i;
      rd_col_q  <= q_col_i;
      fwd_sum_q <= sum_d;
      fwd_sq_q  <= sq_d;
    end
    if (advance) begin
      out_sum_q <= sum_d;
      out_sq_q  <= sq_d;
      out_end_q <= rd_item_q.frame_end;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_valid_q  <= 1'b0;
      rd_fwd_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop) begin
        rd_valid_q <= 1'b1;
        rd_fwd_q   <= advance & (rd_col_q == q_col_i);
      end else if (advance) begin
        rd_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign integral_sum_o = out_sum_q;
  assign square_sum_o   = out_sq_q;
  assign frame_end_o    = out_end_q;

endmodule

`default_nettype wire

[src/iisq_checker.sv]
// port-level checks of occupancy and output hold, bound to the top level
`default_nettype none

module iisq_checker (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           cfg_valid_i,
  input wire logic                           cfg_ready_o,
  input wire logic                           in_valid_i,
  input wire logic                           in_stall_o,
  input wire logic                           out_valid_o,
  input wire logic                           out_stall_i,
  input wire logic [iisq_pkg::SUM_W-1:0]     integral_sum_o,
  input wire logic [iisq_pkg::SQ_W-1:0]      square_sum_o,
  input wire logic                           frame_end_o
);

  // beats in flight: queue, read stage and output register
  localparam int Slots = iisq_pkg::QUEUE_DEPTH + 2;
  localparam int NW    = $clog2(Slots + 1);

  logic [NW-1:0] inflight_q;
  logic          in_beat, out_beat, cfg_beat;

  assign in_beat  = in_valid_i & ~in_stall_o;
  assign out_beat = out_valid_o & ~out_stall_i;
  assign cfg_beat = cfg_valid_i & cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else if (in_beat && !out_beat) begin
      inflight_q <= inflight_q + NW'(1);
    end else if (out_beat && !in_beat) begin
      inflight_q <= inflight_q - NW'(1);
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(integral_sum_o)
      && $stable(square_sum_o) && $stable(frame_end_o))
    else $error("result changed while stalled");

  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> inflight_q != '0)
    else $error("result shown with no pixel in flight");

  a_full_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inflight_q >= NW'(Slots) |-> in_stall_o)
    else $error("pixel taken with every slot occupied");

  a_empty_takes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inflight_q == '0 |-> !in_stall_o && !cfg_beat || !in_stall_o)
    else $error("input stalled while empty");

endmodule

bind integral_and_square_integral_image iisq_checker u_iisq_checker (.*);

`default_nettype wire
